>>> src/mrhr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the median heart rate estimator.
// Used by mrhr_ctrl, mrhr_datapath and median_rr_heart_rate.
package mrhr_pkg;

  localparam int unsigned WINDOW_DEPTH = 5;
  localparam int unsigned MIN_HELD     = 3;

  localparam int unsigned RR_W    = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned HR_W    = 20;

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);

  // One quotient bit per divide step.
  localparam int unsigned DIV_STEPS = HR_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [HR_W-1:0] RATE_NUM_Q4 = HR_W'(960000);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;       // accept request, update ring when item is usable
    logic sel_step;   // test one ring entry as median candidate
    logic div_start;  // init divider
    logic div_step;   // one restoring divide step
    logic out_load;   // move result into output register
  } cmd_t;

  typedef struct packed {
    logic item_ok;    // current request carries a usable interval
    logic enough;     // window will hold at least MIN_HELD after the write
    logic sel_hit;    // candidate sits at the median position
    logic div_last;   // final divide step
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

>>> src/mrhr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the median heart rate estimator: accept, select, divide, output.
// Depends on mrhr_pkg; drives mrhr_datapath through cmd_t / status_t.
module mrhr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mrhr_pkg::status_t status_i,
  output mrhr_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);
  import mrhr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.item_ok && status_i.enough) begin
            state_d = S_SEL;
          end
        end
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (status_i.sel_hit) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> src/mrhr_datapath.sv
`timescale 1ns / 1ps
// Interval ring, rank-based median select, serial divider and output register.
// Depends on mrhr_pkg; sequenced by mrhr_ctrl.
module mrhr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mrhr_pkg::cmd_t                     cmd_i,
  output mrhr_pkg::status_t                  status_o,
  input  logic [mrhr_pkg::RR_W-1:0]          rr_interval_ms_i,
  input  logic                               interval_in_range_i,
  input  logic [mrhr_pkg::STAMP_W-1:0]       beat_time_ms_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [mrhr_pkg::HR_W-1:0]          heart_rate_q4_o,
  output logic [mrhr_pkg::RR_W-1:0]          median_interval_ms_o,
  output logic [mrhr_pkg::STAMP_W-1:0]       estimate_time_ms_o
);
  import mrhr_pkg::*;

  logic [RR_W-1:0]      ring_q [WINDOW_DEPTH];
  logic [CNT_W-1:0]     fill_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [STAMP_W-1:0]   stamp_q;
  logic [SLOT_W-1:0]    sel_idx_q;
  logic [RR_W-1:0]      med_q;
  logic [RR_W-1:0]      rem_q;
  logic [HR_W-1:0]      quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 out_valid_q;
  logic [HR_W-1:0]      out_hr_q;
  logic [RR_W-1:0]      out_med_q;
  logic [STAMP_W-1:0]   out_stamp_q;

  logic               item_ok;
  logic               do_write;
  logic [RR_W-1:0]    cand;
  logic [CNT_W-1:0]   pos;
  logic               sel_hit;
  logic [RR_W:0]      div_trial;
  logic               div_ge;

  assign item_ok  = interval_in_range_i && (rr_interval_ms_i != '0);
  assign do_write = cmd_i.load && item_ok;

  // Sorted position of the candidate: entries below it plus equal entries
  // at lower slots, so equal values get distinct positions.
  assign cand = ring_q[sel_idx_q];
  always_comb begin
    pos = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      if (CNT_W'(j) < fill_q) begin
        if (ring_q[j] < cand) begin
          pos = pos + CNT_W'(1);
        end else if ((ring_q[j] == cand) && (SLOT_W'(j) < sel_idx_q)) begin
          pos = pos + CNT_W'(1);
        end
      end
    end
  end
  assign sel_hit = (pos == (fill_q >> 1));

  assign div_trial = {rem_q, quo_q[HR_W-1]};
  assign div_ge    = (div_trial >= {1'b0, med_q});

  assign status_o.item_ok  = item_ok;
  assign status_o.enough   = (fill_q >= CNT_W'(MIN_HELD - 1));
  assign status_o.sel_hit  = sel_hit;
  assign status_o.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      ring_q[slot_q] <= rr_interval_ms_i;
      stamp_q        <= beat_time_ms_i;
    end
    if (cmd_i.sel_step && sel_hit) begin
      med_q <= cand;
    end
    if (cmd_i.div_start) begin
      quo_q <= RATE_NUM_Q4;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[HR_W-2:0], div_ge};
      rem_q <= div_ge ? RR_W'(div_trial - {1'b0, med_q}) : div_trial[RR_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_hr_q    <= quo_q;
      out_med_q   <= med_q;
      out_stamp_q <= stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      slot_q      <= '0;
      sel_idx_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_write) begin
        slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (cmd_i.load) begin
        sel_idx_q <= '0;
      end else if (cmd_i.sel_step) begin
        sel_idx_q <= sel_idx_q + SLOT_W'(1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign heart_rate_q4_o      = out_hr_q;
  assign median_interval_ms_o = out_med_q;
  assign estimate_time_ms_o   = out_stamp_q;

endmodule

>>> src/median_rr_heart_rate.sv
`timescale 1ns / 1ps
// Running median heart rate estimator, top level.
// Input channel: in_valid_i / in_stall_o with the interval, its in-range flag
// and the beat timestamp. A request is taken when valid is high and stall low.
// An interval that is flagged out of range or is zero is dropped.
// A usable interval goes into a ring of the last five; once three or more are
// held, the median (upper median for four) is picked and 960000 / median is
// computed, giving beats per minute with 4 fraction bits, truncated.
// After an accept, the median position search tests one ring entry per cycle
// until it finds the entry at the median position; the restoring divider then
// forms the 20-bit quotient one bit per cycle, and the output load moves the
// result into the output register. The input stalls from accept until that
// load, so the next request can be taken while the result still waits in the
// output register.
// Output channel: out_valid_o / out_stall_i; while the receiver stalls the
// result holds, and a finished next result waits until the register frees.
// Reset (rst_ni low, asynchronous) empties the window and the output register.
module median_rr_heart_rate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mrhr_pkg::RR_W-1:0]    rr_interval_ms_i,
  input  logic                         interval_in_range_i,
  input  logic [mrhr_pkg::STAMP_W-1:0] beat_time_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mrhr_pkg::HR_W-1:0]    heart_rate_q4_o,
  output logic [mrhr_pkg::RR_W-1:0]    median_interval_ms_o,
  output logic [mrhr_pkg::STAMP_W-1:0] estimate_time_ms_o
);
  import mrhr_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrhr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mrhr_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .rr_interval_ms_i     (rr_interval_ms_i),
    .interval_in_range_i  (interval_in_range_i),
    .beat_time_ms_i       (beat_time_ms_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .heart_rate_q4_o      (heart_rate_q4_o),
    .median_interval_ms_o (median_interval_ms_o),
    .estimate_time_ms_o   (estimate_time_ms_o)
  );

endmodule

>>> verif/median_rr_heart_rate_test.sv
`timescale 1ns / 1ps
// Testbench for median_rr_heart_rate: directed table then random beat intervals.
// Each estimate is checked against a local window-median predictor or a typed row value.
// Depends on mrhr_pkg and the median_rr_heart_rate RTL.
module median_rr_heart_rate_test;
  import mrhr_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [1:0] {
    EXP_PREDICT,  // expectation comes from the predictor
    EXP_NONE,     // request must not produce an estimate
    EXP_TYPED     // expectation typed into the row
  } row_check_e;

  typedef struct packed {
    logic [HR_W-1:0]    rate_q4;
    logic [RR_W-1:0]    median_ms;
    logic [STAMP_W-1:0] stamp_ms;
  } estimate_t;

  typedef struct packed {
    logic [RR_W-1:0]    rr_ms;
    logic               plausible;
    logic [STAMP_W-1:0] stamp_ms;
    row_check_e         check;
    logic [HR_W-1:0]    rate_q4;
    logic [RR_W-1:0]    median_ms;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 20;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'd0,     1'b1, 32'd0,          EXP_NONE,    20'd0,      16'd0},
    '{16'd65535, 1'b0, 32'hFFFF_FFFF,  EXP_NONE,    20'd0,      16'd0},
    '{16'd1000,  1'b1, 32'd1,          EXP_NONE,    20'd0,      16'd0},
    '{16'd0,     1'b0, 32'hAAAA_AAAA,  EXP_NONE,    20'd0,      16'd0},
    '{16'd1,     1'b1, 32'd2,          EXP_NONE,    20'd0,      16'd0},
    '{16'd65535, 1'b1, 32'd3,          EXP_TYPED,   20'd960,    16'd1000},
    // four held: upper median
    '{16'd1,     1'b1, 32'd4,          EXP_TYPED,   20'd960,    16'd1000},
    '{16'd1,     1'b1, 32'hFFFF_FFFF,  EXP_TYPED,   20'd960000, 16'd1},
    // ring wraps, oldest entries overwritten
    '{16'd65535, 1'b1, 32'd0,          EXP_TYPED,   20'd960000, 16'd1},
    '{16'd65535, 1'b1, 32'd5,          EXP_TYPED,   20'd14,     16'd65535},
    '{16'd0,     1'b1, 32'd6,          EXP_NONE,    20'd0,      16'd0},
    '{16'd800,   1'b0, 32'd7,          EXP_NONE,    20'd0,      16'd0},
    '{16'd800,   1'b1, 32'h5555_5555,  EXP_PREDICT, 20'd0,      16'd0},
    '{16'd1200,  1'b1, 32'd8,          EXP_PREDICT, 20'd0,      16'd0},
    '{16'd750,   1'b1, 32'd9,          EXP_PREDICT, 20'd0,      16'd0},
    '{16'd2000,  1'b1, 32'd10,         EXP_PREDICT, 20'd0,      16'd0},
    '{16'd600,   1'b1, 32'd11,         EXP_PREDICT, 20'd0,      16'd0},
    '{16'd32768, 1'b1, 32'd12,         EXP_PREDICT, 20'd0,      16'd0},
    '{16'hAAAA,  1'b1, 32'd13,         EXP_PREDICT, 20'd0,      16'd0},
    '{16'h5555,  1'b1, 32'd14,         EXP_PREDICT, 20'd0,      16'd0}
  };

  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               in_valid_i          = 1'b0;
  logic               in_stall_o;
  logic [RR_W-1:0]    rr_interval_ms_i    = '0;
  logic               interval_in_range_i = 1'b0;
  logic [STAMP_W-1:0] beat_time_ms_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i         = 1'b0;
  logic [HR_W-1:0]    heart_rate_q4_o;
  logic [RR_W-1:0]    median_interval_ms_o;
  logic [STAMP_W-1:0] estimate_time_ms_o;

  median_rr_heart_rate i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .rr_interval_ms_i     (rr_interval_ms_i),
    .interval_in_range_i  (interval_in_range_i),
    .beat_time_ms_i       (beat_time_ms_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .heart_rate_q4_o      (heart_rate_q4_o),
    .median_interval_ms_o (median_interval_ms_o),
    .estimate_time_ms_o   (estimate_time_ms_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the interval window.
  logic [RR_W-1:0]   window_ms [WINDOW_DEPTH];
  int unsigned       held_cnt  = 0;
  int unsigned       next_slot = 0;

  estimate_t         pending_estimates [$];
  logic              steady        = 1'b0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       mismatches    = 0;
  int unsigned       requests_sent = 0;
  int unsigned       dropped       = 0;
  int unsigned       estimates_ok  = 0;
  logic [STAMP_W-1:0] beat_clock   = '0;

  // Updates the window with one request; returns 1 when an estimate follows.
  function automatic logic estimate_heart_rate(input logic [RR_W-1:0] rr,
                                               input logic ok,
                                               input logic [STAMP_W-1:0] stamp,
                                               output estimate_t est);
    logic [RR_W-1:0] ordered [WINDOW_DEPTH];
    logic [RR_W-1:0] swap;
    int unsigned     i, j;
    est = '0;
    if (!ok || rr == '0) return 1'b0;
    window_ms[next_slot] = rr;
    next_slot = (next_slot + 1) % WINDOW_DEPTH;
    if (held_cnt < WINDOW_DEPTH) held_cnt++;
    if (held_cnt < MIN_HELD) return 1'b0;
    for (i = 0; i < held_cnt; i++) ordered[i] = window_ms[i];
    for (i = 0; i < held_cnt; i++) begin
      for (j = 0; j + 1 < held_cnt - i; j++) begin
        if (ordered[j] > ordered[j+1]) begin
          swap         = ordered[j];
          ordered[j]   = ordered[j+1];
          ordered[j+1] = swap;
        end
      end
    end
    est.median_ms = ordered[held_cnt/2];
    est.rate_q4   = HR_W'(32'(RATE_NUM_Q4) / 32'(est.median_ms));
    est.stamp_ms  = stamp;
    return 1'b1;
  endfunction

  // Drives one request, optionally after a gap, and returns once the input no longer stalls.
  task automatic send_request(input logic [RR_W-1:0] rr, input logic ok,
                              input logic [STAMP_W-1:0] stamp);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 30) gap = $urandom_range(1, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    rr_interval_ms_i    <= rr;
    interval_in_range_i <= ok;
    beat_time_ms_i      <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Receiver: random stalls, none in the steady stretch.
  always @(posedge clk_i) begin
    if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    estimate_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{heart_rate_q4_o, median_interval_ms_o, estimate_time_ms_o};
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected estimate: rate %0d median %0d time %0d",
                   seen.rate_q4, seen.median_ms, seen.stamp_ms);
      end else begin
        want = pending_estimates.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("estimate mismatch: expected rate %0d median %0d time %0d, got %0d %0d %0d",
                     want.rate_q4, want.median_ms, want.stamp_ms,
                     seen.rate_q4, seen.median_ms, seen.stamp_ms);
        end else begin
          estimates_ok++;
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    estimate_t       est;
    logic            fires;
    logic [RR_W-1:0] rr;
    logic            ok;
    int unsigned     n, kind;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      send_request(DIRECTED[n].rr_ms, DIRECTED[n].plausible, DIRECTED[n].stamp_ms);
      fires = estimate_heart_rate(DIRECTED[n].rr_ms, DIRECTED[n].plausible,
                                  DIRECTED[n].stamp_ms, est);
      case (DIRECTED[n].check)
        EXP_TYPED: begin
          pending_estimates.push_back('{DIRECTED[n].rate_q4, DIRECTED[n].median_ms,
                                        DIRECTED[n].stamp_ms});
        end
        EXP_PREDICT: begin
          if (fires) pending_estimates.push_back(est);
        end
        default: dropped++;
      endcase
    end

    // Mostly plausible beats with a moving timestamp, some noise and extremes.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) steady <= 1'b1;
      if (n == 250) steady <= 1'b0;
      kind = $urandom_range(99);
      ok   = 1'b1;
      if (kind < 60) rr = RR_W'($urandom_range(300, 2000));
      else if (kind < 75) rr = RR_W'($urandom_range(1, 65535));
      else if (kind < 80) rr = ($urandom_range(1) != 0) ? RR_W'($urandom_range(1, 8)) : '1;
      else if (kind < 90) begin
        rr = RR_W'($urandom_range(0, 65535));
        ok = 1'b0;
      end else begin
        rr = '0;
        ok = 1'($urandom_range(1));
      end
      if ($urandom_range(9) == 0) beat_clock = $urandom;
      else beat_clock = beat_clock + rr;
      send_request(rr, ok, beat_clock);
      fires = estimate_heart_rate(rr, ok, beat_clock, est);
      if (fires) pending_estimates.push_back(est);
      else dropped++;
    end
    in_valid_i <= 1'b0;

    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_estimates.size() != 0) begin
      mismatches += pending_estimates.size();
      $display("%0d estimates never arrived", pending_estimates.size());
    end

    $display("%0d requests sent (%0d gave no estimate), %0d estimates matched, %0d mismatches",
             requests_sent, dropped, estimates_ok, mismatches);
    $display("covered rejected and zero intervals, short window, ring wrap, interval extremes");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
